// File: sv/mbe_pkg.sv
// Shared types, constants and helper functions for the Mandelbrot escape-time pixel engine.
`default_nettype none
package mbe_pkg;

  localparam int FX_W       = 32;
  localparam int PROD_W     = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_W       = 12;
  localparam int CNT_W      = 8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CX,
    ST_CY,
    ST_INIT,
    ST_MXX,
    ST_MYY,
    ST_MXY,
    ST_MCHK,
    ST_DONE
  } state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_START   = 3'd0,
    CFG_Y_START   = 3'd1,
    CFG_X_STEP    = 3'd2,
    CFG_Y_STEP    = 3'd3,
    CFG_MAX_ITER  = 3'd4,
    CFG_ESC_LIMIT = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic signed [FX_W-1:0] x_start;
    logic signed [FX_W-1:0] y_start;
    logic [30:0]            x_step;
    logic [30:0]            y_step;
    logic [CNT_W-1:0]       limit;
    logic [30:0]            esc_limit;
  } cfg_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] count;
  } res_t;

  localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

  function automatic logic signed [FX_W-1:0] sat32(input logic signed [65:0] v);
    logic signed [FX_W-1:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7fffffff;
    end else if (v < SAT_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [65:0] ext66(input logic signed [FX_W-1:0] v);
    return {{34{v[31]}}, v};
  endfunction

  // value below 4096: fold 256 == 1 (mod 255), then one subtract
  function automatic logic [7:0] mod255(input logic [11:0] v);
    logic [8:0] s;
    logic [8:0] d;
    s = {1'b0, v[7:0]} + {5'b0, v[11:8]};
    d = s - 9'd255;
    return (s >= 9'd255) ? d[7:0] : s[7:0];
  endfunction

endpackage
`default_nettype wire

// File: sv/mbe_mul.sv
// Shared signed 32x32 multiplier with a registered 64-bit product.
`default_nettype none
module mbe_mul (
  input  wire logic                                clk,
  input  wire logic signed [mbe_pkg::FX_W-1:0]     a,
  input  wire logic signed [mbe_pkg::FX_W-1:0]     b,
  output logic signed      [mbe_pkg::PROD_W-1:0]   prod
);
  import mbe_pkg::*;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule
`default_nettype wire

// File: sv/mbe_core.sv
// Iteration sequencer and datapath around the shared multiplier.
`default_nettype none
module mbe_core #(
  parameter int FRAC_BITS  = 24,
  parameter int COORD_BITS = 12
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [mbe_pkg::IN_W-1:0]   col,
  input  wire logic [mbe_pkg::IN_W-1:0]   row,
  input  wire mbe_pkg::cfg_t              cfg,
  input  wire logic                       out_free,
  output logic                            ready,
  output mbe_pkg::res_t                   res
);
  import mbe_pkg::*;

  localparam logic [IN_W-1:0] CMASK = IN_W'((64'd1 << COORD_BITS) - 64'd1);

  state_t state;
  state_t state_next;

  logic [IN_W-1:0]        col_q;
  logic [IN_W-1:0]        row_q;
  logic signed [FX_W-1:0] cx;
  logic signed [FX_W-1:0] cy;
  logic signed [FX_W-1:0] x;
  logic signed [FX_W-1:0] y;
  logic signed [FX_W-1:0] x2;
  logic signed [FX_W-1:0] y2;
  logic [CNT_W-1:0]       n;

  logic signed [FX_W-1:0]   mul_a;
  logic signed [FX_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [FX_W-1:0]   fx;
  logic signed [FX_W-1:0]   r2;
  logic signed [FX_W-1:0]   x_next;
  logic signed [FX_W-1:0]   y_next;
  logic signed [FX_W-1:0]   cx_next;
  logic signed [FX_W-1:0]   cy_next;
  logic [CNT_W-1:0]         n_inc;
  logic                     esc;

  mbe_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  always_comb begin
    case (state)
      ST_CX: begin
        mul_a = $signed({{(FX_W-IN_W){1'b0}}, col_q});
        mul_b = $signed({1'b0, cfg.x_step});
      end
      ST_CY: begin
        mul_a = $signed({{(FX_W-IN_W){1'b0}}, row_q});
        mul_b = $signed({1'b0, cfg.y_step});
      end
      ST_MXX: begin
        mul_a = x;
        mul_b = x;
      end
      ST_MYY: begin
        mul_a = y;
        mul_b = y;
      end
      default: begin
        mul_a = x;
        mul_b = y;
      end
    endcase
  end

  assign prod_sh = prod >>> FRAC_BITS;
  assign fx      = sat32({{2{prod_sh[PROD_W-1]}}, prod_sh});
  assign cx_next = sat32(ext66(cfg.x_start) + {{2{prod[PROD_W-1]}}, prod});
  assign cy_next = sat32(ext66(cfg.y_start) + {{2{prod[PROD_W-1]}}, prod});
  assign r2      = sat32(ext66(x2) + ext66(y2));
  assign esc     = {r2[FX_W-1], r2} > $signed({2'b00, cfg.esc_limit});
  assign x_next  = sat32(ext66(x2) - ext66(y2) + ext66(cx));
  assign y_next  = sat32(ext66(fx) + ext66(fx) + ext66(cy));
  assign n_inc   = n + CNT_W'(1);

  always_comb begin
    case (state)
      ST_IDLE: state_next = start ? ST_CX : ST_IDLE;
      ST_CX:   state_next = ST_CY;
      ST_CY:   state_next = ST_INIT;
      ST_INIT: state_next = (cfg.limit == '0) ? ST_DONE : ST_MXX;
      ST_MXX:  state_next = ST_MYY;
      ST_MYY:  state_next = ST_MXY;
      ST_MXY:  state_next = ST_MCHK;
      ST_MCHK: state_next = (esc || n_inc == cfg.limit) ? ST_DONE : ST_MXX;
      ST_DONE: state_next = out_free ? ST_IDLE : ST_DONE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ready     = (state == ST_IDLE);
    res.done  = (state == ST_DONE) && out_free;
    res.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        col_q <= col & CMASK;
        row_q <= row & CMASK;
      end
      ST_CY: begin
        cx <= cx_next;
        x  <= cx_next;
      end
      ST_INIT: begin
        cy <= cy_next;
        y  <= cy_next;
        n  <= '0;
      end
      ST_MYY: x2 <= fx;
      ST_MXY: y2 <= fx;
      ST_MCHK: begin
        if (!esc) begin
          n <= n_inc;
          x <= x_next;
          y <= y_next;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// File: sv/mandelbrot_escape_time_pixel.sv
// Top level: configuration registers, escape-time core and palette output register.
//
//  channel   dir  transfer when            payload
//  s_*       in   s_tvalid & s_tready      s_tdata: col [11:0], row [23:12]
//  m_*       out  m_tvalid & m_tready      m_tdata: iter_count [7:0], argb_color [39:8]
//  cfg_*     in   cfg_we                   cfg_index selects register, cfg_data value
//
// A pixel runs at most 255 iterations; in each, the shared
// multiplier forms x*x, y*y and x*y one after another, then ST_MCHK checks the
// escape and updates z. The setup uses the multiplier twice for c.
// Reset (synchronous) idles the core, drops m_tvalid and restores register defaults.
// A result waits in the output register while the next pixel is taken; the core
// holds its finished count until that register frees.
`default_nettype none
module mandelbrot_escape_time_pixel #(
  parameter int FRAC_BITS  = 24,
  parameter int COORD_BITS = 12,
  parameter int ITER_LIMIT = 255
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [23:0]                        s_tdata,   // col, row
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic [39:0]                             m_tdata,   // iter_count, argb_color
  input  wire logic                               cfg_we,
  input  wire logic [mbe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [mbe_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mbe_pkg::*;

  logic signed [FX_W-1:0] x_start;
  logic signed [FX_W-1:0] y_start;
  logic [30:0]            x_step;
  logic [30:0]            y_step;
  logic [CNT_W-1:0]       max_iter;
  logic [30:0]            escape_limit;

  cfg_t       cfg;
  res_t       res;
  logic       out_free;
  logic       start;
  logic [7:0] n;
  logic [11:0] n7;
  logic [11:0] n13;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_start      <= -32'sd35232153;
      y_start      <= -32'sd29360128;
      x_step       <= 31'd73400;
      y_step       <= 31'd97867;
      max_iter     <= CNT_W'(ITER_LIMIT);
      escape_limit <= 31'd167772160;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_X_START:   x_start      <= cfg_data;
        CFG_Y_START:   y_start      <= cfg_data;
        CFG_X_STEP:    x_step       <= cfg_data[30:0];
        CFG_Y_STEP:    y_step       <= cfg_data[30:0];
        CFG_MAX_ITER:  max_iter     <= cfg_data[CNT_W-1:0];
        CFG_ESC_LIMIT: escape_limit <= cfg_data[30:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.x_start   = x_start;
    cfg.y_start   = y_start;
    cfg.x_step    = x_step;
    cfg.y_step    = y_step;
    cfg.limit     = (max_iter < CNT_W'(ITER_LIMIT)) ? max_iter : CNT_W'(ITER_LIMIT);
    cfg.esc_limit = escape_limit;
  end

  assign start    = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  mbe_core #(
    .FRAC_BITS  (FRAC_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .col      (s_tdata[11:0]),
    .row      (s_tdata[23:12]),
    .cfg      (cfg),
    .out_free (out_free),
    .ready    (s_tready),
    .res      (res)
  );

  assign n   = res.count;
  assign n7  = {1'b0, n, 3'b000} - {4'b0000, n};
  assign n13 = {1'b0, n, 3'b000} + {2'b00, n, 2'b00} + {4'b0000, n};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.done) begin
      m_tdata <= {8'hFF, mod255({4'b0000, n}), mod255(n7), mod255(n13), n};
    end
  end

endmodule
`default_nettype wire

// File: sv/mbe_checker.sv
// Port-level checks for the escape-time pixel engine, bound to the top level.
`default_nettype none
module mbe_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("pixel taken while busy");

  a_alpha: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[39:32] == 8'hFF)
    else $error("alpha byte wrong");

  a_red: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[31:24] == m_tdata[7:0] && m_tdata[7:0] != 8'hFF) ||
                 (m_tdata[31:24] == 8'h00 && m_tdata[7:0] == 8'hFF))
    else $error("red byte does not follow count");

endmodule

bind mandelbrot_escape_time_pixel mbe_checker u_chk (.*);
`default_nettype wire

// File: verif/escape_checker.sv
// Checker for the escape-time pixel engine: tracks the registers, predicts each pixel, compares.
module escape_checker #(
  parameter int FRAC_BITS  = 24,
  parameter int COORD_BITS = 12,
  parameter int ITER_LIMIT = 255
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [23:0]                    s_tdata,   // col [11:0], row [23:12]
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [39:0]                    m_tdata,   // iter_count [7:0], argb_color [39:8]
  input  logic                           cfg_we,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbe_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fails,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import mbe_pkg::*;

  localparam longint FX_MAX = 64'sd2147483647;
  localparam longint FX_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [11:0] col;
    logic [11:0] row;
    logic [7:0]  count;
    logic [31:0] argb;
  } pixel_t;

  logic signed [31:0] x_start_r;
  logic signed [31:0] y_start_r;
  logic [30:0]        x_step_r;
  logic [30:0]        y_step_r;
  logic [7:0]         max_iter_r;
  logic [30:0]        esc_r;
  pixel_t             expected_q[$];

  function automatic logic signed [31:0] clamp_fx(input longint v);
    if (v > FX_MAX) return 32'sh7fffffff;
    if (v < FX_MIN) return 32'sh80000000;
    return v[31:0];
  endfunction

  // exact product, floor shift, then saturate
  function automatic logic signed [31:0] fx_product(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return clamp_fx(p >>> FRAC_BITS);
  endfunction

  function automatic pixel_t escape_pixel(input logic [11:0] col, input logic [11:0] row);
    longint             cmask;
    longint             pc;
    longint             pr;
    longint             stx;
    longint             sty;
    longint             esc;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] x2;
    logic signed [31:0] y2;
    logic signed [31:0] xy;
    logic signed [31:0] r2;
    int                 lim;
    int                 n;
    int                 red;
    int                 grn;
    int                 blu;
    bit                 escaped;
    pixel_t             px;
    cmask = (longint'(1) << COORD_BITS) - 1;
    pc = col;
    pr = row;
    pc = pc & cmask;
    pr = pr & cmask;
    stx = x_step_r;
    sty = y_step_r;
    esc = esc_r;
    cx = clamp_fx(longint'(x_start_r) + pc * stx);
    cy = clamp_fx(longint'(y_start_r) + pr * sty);
    x = cx;
    y = cy;
    lim = (max_iter_r < ITER_LIMIT) ? int'(max_iter_r) : ITER_LIMIT;
    n = 0;
    escaped = 1'b0;
    while (!escaped && n < lim) begin
      x2 = fx_product(x, x);
      y2 = fx_product(y, y);
      xy = fx_product(x, y);
      r2 = clamp_fx(longint'(x2) + longint'(y2));
      if (longint'(r2) > esc) begin
        escaped = 1'b1;
      end else begin
        n++;
        x = clamp_fx(longint'(x2) - longint'(y2) + longint'(cx));
        y = clamp_fx(longint'(xy) + longint'(xy) + longint'(cy));
      end
    end
    red = n % 255;
    grn = (n * 7) % 255;
    blu = (n * 13) % 255;
    px.col = col;
    px.row = row;
    px.count = n[7:0];
    px.argb = {8'hFF, red[7:0], grn[7:0], blu[7:0]};
    return px;
  endfunction

  task automatic report_error(input string msg);
    $display("%0t pixel check: %s", $time, msg);
    fails++;
  endtask

  always @(posedge clk) begin : track
    pixel_t want;
    if (rst) begin
      x_start_r = -32'sd35232153;
      y_start_r = -32'sd29360128;
      x_step_r = 31'd73400;
      y_step_r = 31'd97867;
      max_iter_r = ITER_LIMIT[7:0];
      esc_r = 31'd167772160;
      expected_q.delete();
      fails = 0;
      pending <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          report_error($sformatf("result with nothing pending: count %0d argb %08h",
                                 m_tdata[7:0], m_tdata[39:8]));
        end else begin
          want = expected_q.pop_front();
          if (m_tdata[7:0] !== want.count) begin
            report_error($sformatf("pixel (%0d,%0d) iter_count %0d, want %0d",
                                   want.col, want.row, m_tdata[7:0], want.count));
          end
          if (m_tdata[39:8] !== want.argb) begin
            report_error($sformatf("pixel (%0d,%0d) argb_color %08h, want %08h",
                                   want.col, want.row, m_tdata[39:8], want.argb));
          end
        end
      end
      if (s_tvalid && s_tready) begin
        expected_q.push_back(escape_pixel(s_tdata[11:0], s_tdata[23:12]));
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_X_START:   x_start_r = cfg_data;
          CFG_Y_START:   y_start_r = cfg_data;
          CFG_X_STEP:    x_step_r = cfg_data[30:0];
          CFG_Y_STEP:    y_step_r = cfg_data[30:0];
          CFG_MAX_ITER:  max_iter_r = cfg_data[7:0];
          CFG_ESC_LIMIT: esc_r = cfg_data[30:0];
          default: ;
        endcase
      end
      pending <= expected_q.size();
    end
  end

endmodule

// File: verif/testbench.sv
// Top of the escape-time pixel engine testbench: clock, reset, stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mbe_pkg::*;

  localparam int FRAC_BITS    = 24;
  localparam int COORD_BITS   = 12;
  localparam int ITER_LIMIT   = 255;
  localparam int IDLE_LIMIT   = 6000;
  localparam int PHASES       = 12;
  localparam int PHASE_PIXELS = 61;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [23:0]           s_tdata = '0;   // col [11:0], row [23:12]
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [39:0]           m_tdata;        // iter_count [7:0], argb_color [39:8]
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    fails;
  int                    pending;
  int                    src_quiet = 0;
  int                    snk_quiet = 0;

  mandelbrot_escape_time_pixel #(
    .FRAC_BITS (FRAC_BITS),
    .COORD_BITS(COORD_BITS),
    .ITER_LIMIT(ITER_LIMIT)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  escape_checker #(
    .FRAC_BITS (FRAC_BITS),
    .COORD_BITS(COORD_BITS),
    .ITER_LIMIT(ITER_LIMIT)
  ) pixel_check (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .fails    (fails),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // wait count per transfer, with bursts of back-to-back transfers
  task automatic draw_wait(inout int quiet, output int n);
    if (quiet > 0) begin
      quiet--;
      n = 0;
    end else if ($urandom_range(0, 15) == 0) begin
      quiet = $urandom_range(5, 40);
      n = 0;
    end else begin
      n = $urandom_range(0, 10);
    end
  endtask

  task automatic send_pixel(input logic [11:0] col, input logic [11:0] row);
    int n;
    draw_wait(src_quiet, n);
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {row, col};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // hold off the source until every pending pixel has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic load_view(input logic [31:0] xs, input logic [31:0] ys,
                           input logic [31:0] xst, input logic [31:0] yst,
                           input logic [31:0] mi, input logic [31:0] el);
    write_reg(CFG_X_START, xs);
    write_reg(CFG_Y_START, ys);
    write_reg(CFG_X_STEP, xst);
    write_reg(CFG_Y_STEP, yst);
    write_reg(CFG_MAX_ITER, mi);
    write_reg(CFG_ESC_LIMIT, el);
    cfg_we <= 1'b0;
  endtask

  initial begin : sink
    int n;
    while (rst) @(posedge clk);
    forever begin
      draw_wait(snk_quiet, n);
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
      else idle++;
    end
    $display("testbench: done, errors");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] xs;
    logic [31:0] ys;
    logic [31:0] xst;
    logic [31:0] yst;
    logic [31:0] mi;
    logic [31:0] el;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset view: origin never escapes, corners other than (0,0) escape at once
    send_pixel(12'd480, 12'd300);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd481, 12'd300);
    drain();
    write_reg(CFG_MAX_ITER, 32'h0);
    write_reg(CFG_SPARE_LO, $urandom);
    write_reg(CFG_SPARE_HI, $urandom);
    cfg_we <= 1'b0;
    send_pixel(12'd480, 12'd300);
    send_pixel(12'd100, 12'd200);
    drain();
    write_reg(CFG_MAX_ITER, 32'hFFFFFF01);
    write_reg(CFG_ESC_LIMIT, 32'h0);
    cfg_we <= 1'b0;
    send_pixel(12'd480, 12'd300);
    send_pixel(12'd0, 12'd0);
    drain();
    write_reg(CFG_ESC_LIMIT, 32'hFFFFFFFF);
    write_reg(CFG_MAX_ITER, 32'd7);
    cfg_we <= 1'b0;
    send_pixel(12'd480, 12'd300);
    send_pixel(12'd4095, 12'd4095);
    drain();
    load_view(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h80000000, 32'd3, 32'd67108864);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    drain();
    load_view(32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h7FFFFFFF, 32'd255, 32'd167772160);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd0);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin
          xs = -41943040 + int'($urandom_range(0, 33554432));
          ys = -25165824 + int'($urandom_range(0, 8388608));
          xst = $urandom_range(2000, 16000);
          yst = $urandom_range(2000, 16000);
          mi = $urandom_range(16, 64);
          el = 67108864;
        end
        1: begin
          xs = -16777216 + int'($urandom_range(0, 8388608));
          ys = -2097152 + int'($urandom_range(0, 4194304));
          xst = $urandom_range(1, 600);
          yst = $urandom_range(1, 600);
          mi = $urandom_range(100, 255);
          el = $urandom_range(50331648, 167772160);
        end
        2: begin
          xs = $urandom;
          ys = $urandom;
          xst = $urandom;
          yst = $urandom;
          mi = $urandom;
          el = $urandom;
        end
        default: begin
          xs = -35232153;
          ys = -29360128;
          xst = 73400;
          yst = 97867;
          mi = $urandom_range(1, 255);
          case ($urandom_range(0, 3))
            0: el = 32'h0;
            1: el = 32'd67108864;
            2: el = 32'd167772160;
            default: el = 32'hFFFFFFFF;
          endcase
        end
      endcase
      load_view(xs, ys, xst, yst, mi, el);
      for (int k = 0; k < PHASE_PIXELS; k++) begin
        if (ph == 5 && k == 30) drain();
        send_pixel(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
      end
      drain();
    end

    repeat (50) @(posedge clk);
    if (fails == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/mbe_pkg.sv
sv/mbe_mul.sv
sv/mbe_core.sv
sv/mandelbrot_escape_time_pixel.sv
sv/mbe_checker.sv
verif/escape_checker.sv
verif/testbench.sv
